FILE: hw/rtl/cle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg
// Types and constants shared by the console line editor modules.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LenW       = 6;
  localparam int CntW       = 6;
  localparam int MaxResults = 37;

  localparam logic [7:0] KEsc     = 8'h1B;
  localparam logic [7:0] KBracket = 8'h5B;
  localparam logic [7:0] KUp      = 8'h41;
  localparam logic [7:0] KDown    = 8'h42;
  localparam logic [7:0] KCr      = 8'h0D;
  localparam logic [7:0] KLf      = 8'h0A;
  localparam logic [7:0] KBs      = 8'h08;
  localparam logic [7:0] KDel     = 8'h7F;
  localparam logic [7:0] PTilde   = 8'h7E;
  localparam logic [7:0] PDollar  = 8'h24;
  localparam logic [7:0] PSpace   = 8'h20;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_ERASE,
    OP_ENTER,
    OP_UP,
    OP_DOWN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cle_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_front
// Accepts received bytes, tracks escape sequences and queues edit commands.
// ----------------------------------------------------------------------------
module cle_front import cle_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       q_ready_i,
  output      logic       q_valid_o,
  output      cmd_t       q_cmd_o
);

  logic esc_q, esc_d;
  logic brk_q, brk_d;
  logic acc;

  assign in_ready_o = q_ready_i;
  assign acc        = in_valid_i && q_ready_i;

  always_comb begin
    esc_d        = esc_q;
    brk_d        = brk_q;
    q_valid_o    = 1'b0;
    q_cmd_o.op   = OP_CHAR;
    q_cmd_o.data = rx_byte_i;
    if (acc) begin
      if (esc_q) begin
        if (rx_byte_i == KBracket) begin
          brk_d = 1'b1;
        end else begin
          if (brk_q && rx_byte_i == KUp) begin
            q_valid_o  = 1'b1;
            q_cmd_o.op = OP_UP;
          end else if (brk_q && rx_byte_i == KDown) begin
            q_valid_o  = 1'b1;
            q_cmd_o.op = OP_DOWN;
          end
          esc_d = 1'b0;
          brk_d = 1'b0;
        end
      end else if (rx_byte_i == KCr) begin
        q_valid_o  = 1'b1;
        q_cmd_o.op = OP_ENTER;
      end else if (rx_byte_i == KBs || rx_byte_i == KDel) begin
        q_valid_o  = 1'b1;
        q_cmd_o.op = OP_ERASE;
      end else if (rx_byte_i == KEsc) begin
        esc_d = 1'b1;
      end else begin
        q_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      brk_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
      brk_q <= brk_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cle_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module cle_fifo import cle_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output      hs_t  stat_o,
  input  wire logic pop_i,
  output      cmd_t pop_cmd_o
);

  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign stat_o.ready = (cnt_q != 2'd2);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign pop_cmd_o    = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cle_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_back
// Executes edit commands: line buffer, history ring, echo and commit beats.
// ----------------------------------------------------------------------------
module cle_back import cle_pkg::*; #(
  parameter int LINE_LEN   = 32,
  parameter int HIST_DEPTH = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hs_t        q_stat_i,
  input  wire cmd_t       q_cmd_i,
  output      logic       q_pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic       out_kind_o,
  output      logic [7:0] out_byte_o,
  output      logic       out_last_o
);

  localparam int LIW  = $clog2(LINE_LEN);
  localparam int HW   = $clog2(HIST_DEPTH * LINE_LEN);
  localparam int SW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int OW   = $clog2(HIST_DEPTH + 1);
  localparam int SumW = OW + 1;
  localparam logic [HW-1:0]   LineLenH = HW'(LINE_LEN);
  localparam logic [LenW-1:0] LineLenL = LenW'(LINE_LEN);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_PROMPT = 3'b010,
    S_COPY   = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic            enter_q, enter_d;
  logic [2:0]      pidx_q, pidx_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_n;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] clen_q, clen_d;
  logic [HW-1:0]   hbase_q, hbase_d;
  logic [SW-1:0]   wslot_q, wslot_d;
  logic [OW-1:0]   off_q, off_d;
  logic [LenW-1:0] hlen_q [HIST_DEPTH];

  logic            outv_q, outv_d;
  logic            outk_q, outk_d;
  logic [7:0]      outb_q, outb_d;
  logic            outl_q, outl_d;

  logic [7:0]      line_mem [LINE_LEN];
  logic [7:0]      hist_mem [HIST_DEPTH * LINE_LEN];
  logic [7:0]      line_rd_q, hist_rd_q;
  logic            line_we, line_re, hist_we, hist_re;
  logic [LIW-1:0]  line_wa, line_ra;
  logic [HW-1:0]   hist_wa, hist_ra;
  logic [7:0]      line_wd, hist_wd;
  logic            hlen_we;

  logic            adv;
  logic            emit, e_kind, e_final, e_cap;
  logic [7:0]      e_byte;
  logic [OW-1:0]   newoff;
  logic [SumW-1:0] ssum, sslot;
  logic [SW-1:0]   slot;
  logic [HW-1:0]   sbase;
  logic [LenW-1:0] nidx;
  logic            finish;

  assign adv  = !outv_q || out_ready_i;
  assign nidx = idx_q + LenW'(1);

  always_comb begin
    if (q_cmd_i.op == OP_UP) begin
      newoff = (off_q < OW'(HIST_DEPTH)) ? off_q + OW'(1) : off_q;
    end else begin
      newoff = (off_q != '0) ? off_q - OW'(1) : '0;
    end
    ssum  = SumW'(wslot_q) + SumW'(HIST_DEPTH) - SumW'(newoff);
    sslot = (ssum >= SumW'(HIST_DEPTH)) ? ssum - SumW'(HIST_DEPTH) : ssum;
    slot  = sslot[SW-1:0];
    sbase = HW'(slot) * LineLenH;
  end

  always_comb begin
    state_d = state_q;
    enter_d = enter_q;
    pidx_d  = pidx_q;
    idx_d   = idx_q;
    cnt_n   = cnt_q;
    len_d   = len_q;
    clen_d  = clen_q;
    hbase_d = hbase_q;
    wslot_d = wslot_q;
    off_d   = off_q;
    q_pop_o = 1'b0;
    emit    = 1'b0;
    e_kind  = 1'b0;
    e_byte  = q_cmd_i.data;
    e_final = 1'b1;
    e_cap   = 1'b0;
    line_we = 1'b0;
    line_wa = len_q[LIW-1:0];
    line_wd = q_cmd_i.data;
    line_re = 1'b0;
    line_ra = '0;
    hist_we = 1'b0;
    hist_wa = hbase_q + HW'(idx_q);
    hist_wd = line_rd_q;
    hist_re = 1'b0;
    hist_ra = sbase;
    hlen_we = 1'b0;
    finish  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (adv && q_stat_i.valid) begin
          q_pop_o = 1'b1;
          cnt_n   = '0;
          pidx_d  = '0;
          idx_d   = '0;
          case (q_cmd_i.op)
            OP_CHAR: begin
              if (len_q < LineLenL) begin
                line_we = 1'b1;
                len_d   = len_q + LenW'(1);
                emit    = 1'b1;
              end
            end
            OP_ERASE: begin
              if (len_q != '0) begin
                len_d = len_q - LenW'(1);
                emit  = 1'b1;
              end
            end
            OP_ENTER: begin
              enter_d = 1'b1;
              clen_d  = len_q;
              hbase_d = HW'(wslot_q) * LineLenH;
              line_re = 1'b1;
              state_d = S_PROMPT;
            end
            OP_UP, OP_DOWN: begin
              enter_d = 1'b0;
              off_d   = newoff;
              state_d = S_PROMPT;
              if (q_cmd_i.op == OP_UP || newoff != '0) begin
                clen_d  = hlen_q[slot];
                hbase_d = sbase;
                hist_re = 1'b1;
              end else begin
                clen_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PROMPT: begin
        if (adv) begin
          emit  = 1'b1;
          e_cap = 1'b1;
          case (pidx_q)
            3'd0:    e_byte = KCr;
            3'd1:    e_byte = KLf;
            3'd2:    e_byte = PTilde;
            3'd3:    e_byte = PDollar;
            default: e_byte = PSpace;
          endcase
          e_final = (pidx_q == 3'd4) && (clen_q == '0);
          if (pidx_q == 3'd0 && !enter_q) begin
            pidx_d = 3'd2;
          end else begin
            pidx_d = pidx_q + 3'd1;
          end
          if (pidx_q == 3'd4) begin
            if (clen_q == '0) begin
              finish = 1'b1;
            end else begin
              state_d = S_COPY;
            end
          end
        end
      end
      S_COPY: begin
        if (adv) begin
          emit    = 1'b1;
          e_cap   = 1'b1;
          e_kind  = enter_q;
          e_byte  = enter_q ? line_rd_q : hist_rd_q;
          e_final = (nidx == clen_q);
          if (enter_q) begin
            hist_we = 1'b1;
          end else begin
            line_we = 1'b1;
            line_wa = idx_q[LIW-1:0];
            line_wd = hist_rd_q;
          end
          if (nidx == clen_q) begin
            finish = 1'b1;
          end else begin
            idx_d   = nidx;
            line_re = enter_q;
            line_ra = nidx[LIW-1:0];
            hist_re = !enter_q;
            hist_ra = hbase_q + HW'(nidx);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      state_d = S_IDLE;
      if (enter_q) begin
        len_d = '0;
        if (clen_q != '0) begin
          hlen_we = 1'b1;
          wslot_d = (32'(wslot_q) == HIST_DEPTH - 1) ? '0 : wslot_q + SW'(1);
        end
      end else begin
        len_d = clen_q;
      end
    end
  end

  always_comb begin
    outv_d = outv_q && !out_ready_i;
    outk_d = outk_q;
    outb_d = outb_q;
    outl_d = outl_q;
    cnt_d  = cnt_n;
    if (emit && (!e_cap || cnt_q < CntW'(MaxResults))) begin
      outv_d = 1'b1;
      outk_d = e_kind;
      outb_d = e_byte;
      outl_d = e_final || (e_cap && cnt_q == CntW'(MaxResults - 1));
      cnt_d  = cnt_n + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
    if (line_re) begin
      line_rd_q <= line_mem[line_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    outk_q <= outk_d;
    outb_q <= outb_d;
    outl_q <= outl_d;
    enter_q <= enter_d;
    pidx_q  <= pidx_d;
    idx_q   <= idx_d;
    clen_q  <= clen_d;
    hbase_q <= hbase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      len_q   <= '0;
      wslot_q <= '0;
      off_q   <= '0;
      outv_q  <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hlen_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      wslot_q <= wslot_d;
      off_q   <= off_d;
      outv_q  <= outv_d;
      if (hlen_we) begin
        hlen_q[wslot_q] <= clen_q;
      end
    end
  end

  assign out_valid_o = outv_q;
  assign out_kind_o  = outk_q;
  assign out_byte_o  = outb_q;
  assign out_last_o  = outl_q;

endmodule
`default_nettype wire

FILE: hw/rtl/console_line_editor_with_history_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// console_line_editor_with_history_unit
// Terminal line editor with a history ring of committed lines.
//
// Input channel: one received byte per beat (rx_byte_i, in_valid_i/in_ready_o).
// Output channel: echo beats (out_kind_o = 0) and committed line beats
// (out_kind_o = 1); out_last_o marks the last beat caused by one input byte.
// A front stage decodes escape sequences and queues commands in a two-entry
// queue; the back stage runs them against the line and history memories.
// A printable byte gives one beat unless the line is full, and an erase
// one unless the line is empty. Enter gives 5 + n beats and a recall 4 + n
// beats, one per cycle while the receiver does not stall, where n is the
// line or history entry length; the back emits at most 37 beats per byte.
// Swallowed escape bytes never reach the back stage. Input is taken
// while the queue has room.
// Reset clears the line, escape state, history lengths and recall position;
// no clearing pass runs. A stalled receiver holds the output register and
// the back stage; the queue then fills and in_ready_o drops.
// ----------------------------------------------------------------------------
module console_line_editor_with_history_unit import cle_pkg::*; #(
  parameter int LINE_LEN   = 32,
  parameter int HIST_DEPTH = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic       out_kind_o,
  output      logic [7:0] out_byte_o,
  output      logic       out_last_o
);

  hs_t  q_stat;
  logic push, pop;
  cmd_t push_cmd, pop_cmd;

  cle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_ready_i  (q_stat.ready),
    .q_valid_o  (push),
    .q_cmd_o    (push_cmd)
  );

  cle_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .stat_o     (q_stat),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd)
  );

  cle_back #(
    .LINE_LEN   (LINE_LEN),
    .HIST_DEPTH (HIST_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/cle_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks on the line editor output stream.
// ----------------------------------------------------------------------------
module cle_checker import cle_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       out_kind_o,
  input wire logic [7:0] out_byte_o,
  input wire logic       out_last_o
);

  logic       first_q;
  logic       pkind_q;
  logic [7:0] pbyte_q;
  logic       acc;

  assign acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      pkind_q <= 1'b0;
      pbyte_q <= 8'h00;
    end else if (acc) begin
      first_q <= out_last_o;
      pkind_q <= out_kind_o;
      pbyte_q <= out_byte_o;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_kind_o) && $stable(out_last_o))
    else $error("output beat changed while stalled");

  a_first_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q |-> !out_kind_o)
    else $error("first beat of a byte is not an echo");

  a_commit_after_prompt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_kind_o && !pkind_q |-> pbyte_q == PSpace && !first_q)
    else $error("committed line does not follow the prompt");

endmodule

bind console_line_editor_with_history_unit cle_checker u_cle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_kind_o  (out_kind_o),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);
`default_nettype wire
